>>> rtl/core/calendar_clock_counter_top_defines.svh
// Assertion macros shared by the calendar clock RTL.
// Each macro takes a label, the clock, the reset and the two sides of the implication.
`ifndef CALENDAR_CLOCK_COUNTER_TOP_DEFINES_SVH
`define CALENDAR_CLOCK_COUNTER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("calendar clock check failed");

// Consequent must hold in the cycle after the antecedent.
`define CCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("calendar clock check failed");

`endif

>>> rtl/core/ccc_pkg.sv
`timescale 1ns / 1ps

package ccc_pkg;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_LOAD = 2'd1,
    REQ_MARK = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  localparam logic [15:0] YEAR_AT_RESET = 16'd2000;
  localparam logic [5:0]  SEC_LAST      = 6'd59;
  localparam logic [5:0]  MIN_LAST      = 6'd59;
  localparam logic [4:0]  HOUR_LAST     = 5'd23;
  localparam logic [2:0]  WDAY_LAST     = 3'd6;
  localparam logic [3:0]  MONTH_LAST    = 4'd12;

  // Divisibility by 25 through the modular inverse of 25: x is a multiple of 25
  // exactly when x times the inverse, modulo the word size, is no more than the
  // largest multiple count that fits.
  localparam logic [13:0] INV25_14 = 14'd7209;
  localparam logic [13:0] LIM25_14 = 14'd655;
  localparam logic [11:0] INV25_12 = 12'd3113;
  localparam logic [11:0] LIM25_12 = 12'd163;

  function automatic logic leap_year(input logic [15:0] y);
    logic [13:0] p14;
    logic [11:0] p12;
    logic        div100;
    logic        div400;
    p14    = y[15:2] * INV25_14;
    p12    = y[15:4] * INV25_12;
    div100 = (y[1:0] == 2'd0) && (p14 <= LIM25_14);
    div400 = (y[3:0] == 4'd0) && (p12 <= LIM25_12);
    return (y[1:0] == 2'd0) && (!div100 || div400);
  endfunction

  // Month length; a month outside January to December counts as 31 days.
  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                       d = leap ? 5'd29 : 5'd28;
      default:                                    d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/core/calendar_clock_counter_top.sv
// Calendar clock: one request word in, one time word out per request.
// A request moves from the request register into the time registers, which hold
// its result. Throughput: one request per cycle unless the output stalls; the
// update is a single pass of compare and increment logic across them.
// Reset (synchronous, active high) loads 1 January 2000, 00:00:00, weekday 0,
// zone 0, not synchronised, and empties both stages.
`timescale 1ns / 1ps
`include "calendar_clock_counter_top_defines.svh"

module calendar_clock_counter_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [15:0]        set_year,
  input  logic [3:0]         set_month,
  input  logic [4:0]         set_day,
  input  logic [2:0]         set_weekday,
  input  logic [4:0]         set_hour,
  input  logic [5:0]         set_minute,
  input  logic [5:0]         set_second,
  input  logic signed [15:0] set_zone,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        cur_year,
  output logic [3:0]         cur_month,
  output logic [4:0]         cur_day,
  output logic [2:0]         cur_weekday,
  output logic [4:0]         cur_hour,
  output logic [5:0]         cur_minute,
  output logic [5:0]         cur_second,
  output logic signed [15:0] cur_zone,
  output logic               is_synced
);

  // Request register. It holds one accepted word until the time registers are
  // free to take its outcome.
  logic               s1_valid;
  ccc_pkg::req_t      s1_req;
  logic [15:0]        s1_year;
  logic [3:0]         s1_month;
  logic [4:0]         s1_day;
  logic [2:0]         s1_weekday;
  logic [4:0]         s1_hour;
  logic [5:0]         s1_minute;
  logic [5:0]         s1_second;
  logic signed [15:0] s1_zone;

  // The time registers are the result register as well: they only change when
  // the result they show has been taken (or none is showing), so the output
  // word stays put while the consumer stalls.
  logic [15:0]        year_count, year_count_next;
  logic [3:0]         month_count, month_count_next;
  logic [4:0]         day_count, day_count_next;
  logic [2:0]         weekday_count, weekday_count_next;
  logic [4:0]         hour_count, hour_count_next;
  logic [5:0]         minute_count, minute_count_next;
  logic [5:0]         second_count, second_count_next;
  logic signed [15:0] zone_value, zone_value_next;
  logic               synced_flag, synced_flag_next;

  logic               fire;
  logic               leap;
  logic [4:0]         dim;

  // The pending request moves on whenever the output slot is empty or being
  // emptied; the request register refills in the same cycle.
  assign fire     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || fire;

  assign leap = ccc_pkg::leap_year(year_count);
  assign dim  = ccc_pkg::days_in_month(month_count, leap);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_req     <= ccc_pkg::req_t'(req_type);
      s1_year    <= set_year;
      s1_month   <= set_month;
      s1_day     <= set_day;
      s1_weekday <= set_weekday;
      s1_hour    <= set_hour;
      s1_minute  <= set_minute;
      s1_second  <= set_second;
      s1_zone    <= set_zone;
    end
  end

  // Cascaded carry: each unit only moves when everything below it wrapped.
  // The weekday and the day both take the carry out of the hours.
  always_comb begin
    year_count_next    = year_count;
    month_count_next   = month_count;
    day_count_next     = day_count;
    weekday_count_next = weekday_count;
    hour_count_next    = hour_count;
    minute_count_next  = minute_count;
    second_count_next  = second_count;
    zone_value_next    = zone_value;
    synced_flag_next   = synced_flag;
    case (s1_req)
      ccc_pkg::REQ_TICK: begin
        if (second_count < ccc_pkg::SEC_LAST) begin
          second_count_next = second_count + 6'd1;
        end else begin
          second_count_next = 6'd0;
          if (minute_count < ccc_pkg::MIN_LAST) begin
            minute_count_next = minute_count + 6'd1;
          end else begin
            minute_count_next = 6'd0;
            if (hour_count < ccc_pkg::HOUR_LAST) begin
              hour_count_next = hour_count + 5'd1;
            end else begin
              hour_count_next = 5'd0;
              if (weekday_count < ccc_pkg::WDAY_LAST) begin
                weekday_count_next = weekday_count + 3'd1;
              end else begin
                weekday_count_next = 3'd0;
              end
              if (day_count < dim) begin
                day_count_next = day_count + 5'd1;
              end else begin
                day_count_next = 5'd1;
                if (month_count < ccc_pkg::MONTH_LAST) begin
                  month_count_next = month_count + 4'd1;
                end else begin
                  month_count_next = 4'd1;
                  year_count_next  = year_count + 16'd1;
                end
              end
            end
          end
        end
      end
      ccc_pkg::REQ_LOAD: begin
        year_count_next    = s1_year;
        month_count_next   = s1_month;
        day_count_next     = s1_day;
        weekday_count_next = s1_weekday;
        hour_count_next    = s1_hour;
        minute_count_next  = s1_minute;
        second_count_next  = s1_second;
        zone_value_next    = s1_zone;
        synced_flag_next   = 1'b1;
      end
      ccc_pkg::REQ_MARK: begin
        synced_flag_next = 1'b1;
      end
      default: begin
        // An unused request code leaves the time as it is and still reports it.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      year_count    <= ccc_pkg::YEAR_AT_RESET;
      month_count   <= 4'd1;
      day_count     <= 5'd1;
      weekday_count <= 3'd0;
      hour_count    <= 5'd0;
      minute_count  <= 6'd0;
      second_count  <= 6'd0;
      zone_value    <= 16'sd0;
      synced_flag   <= 1'b0;
    end else begin
      if (fire) begin
        out_valid     <= 1'b1;
        year_count    <= year_count_next;
        month_count   <= month_count_next;
        day_count     <= day_count_next;
        weekday_count <= weekday_count_next;
        hour_count    <= hour_count_next;
        minute_count  <= minute_count_next;
        second_count  <= second_count_next;
        zone_value    <= zone_value_next;
        synced_flag   <= synced_flag_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign cur_year    = year_count;
  assign cur_month   = month_count;
  assign cur_day     = day_count;
  assign cur_weekday = weekday_count;
  assign cur_hour    = hour_count;
  assign cur_minute  = minute_count;
  assign cur_second  = second_count;
  assign cur_zone    = zone_value;
  assign is_synced   = synced_flag;

  // A stalled result must not be disturbed by the next request.
  `CCC_ASSERT_NEXT(a_stall_holds_time, clk, rst, out_valid && !out_ready,
    $stable(second_count) && $stable(day_count) && $stable(year_count))

  // With both stages full and the output stalled, nothing more may enter.
  `CCC_ASSERT_SAME(a_full_blocks_input, clk, rst, s1_valid && out_valid && !out_ready,
    !in_ready)

  // A tick below the last second only advances the seconds.
  `CCC_ASSERT_NEXT(a_tick_counts_second, clk, rst,
    fire && (s1_req == ccc_pkg::REQ_TICK) && (second_count < ccc_pkg::SEC_LAST),
    (second_count == $past(second_count) + 6'd1) && $stable(minute_count))

  // A load or a mark leaves the clock synchronised.
  `CCC_ASSERT_NEXT(a_sync_set, clk, rst,
    fire && ((s1_req == ccc_pkg::REQ_LOAD) || (s1_req == ccc_pkg::REQ_MARK)),
    synced_flag && out_valid)

endmodule
